@@ hdl/crg_pkg.sv @@
// Shared constants, types and saturation helpers for the camera primary ray generator.
`default_nettype none

package crg_pkg;

    // Defaults for the top-level parameters.
    localparam int PIXEL_BITS_DEF    = 12;
    localparam int DIR_FRAC_BITS_DEF = 14;

    // Fixed field widths.
    localparam int FRACT_BITS = 16;
    localparam int VEC_BITS   = 16;
    localparam int SCALE_BITS = 16;
    localparam int POS_BITS   = 20;
    localparam int DIR_BITS   = 16;

    // Internal datapath widths.
    localparam int PX_BITS    = FRACT_BITS + 1;
    localparam int PS_BITS    = PX_BITS + SCALE_BITS + 1;
    localparam int OP_BITS    = PX_BITS + POS_BITS + 1;
    localparam int LP_BITS    = VEC_BITS + PS_BITS;
    localparam int FWD_SHIFT  = 28;
    localparam int V_BITS     = 51;
    localparam int MAG_BITS   = 48;
    localparam int NORM_BITS  = 30;
    localparam int NORM_STEPS = 6;
    localparam int SQR_BITS   = 2 * NORM_BITS;
    localparam int SQ_BITS    = 62;
    localparam int ROOT_BITS  = 31;
    localparam int REM_BITS   = 34;
    localparam int WIDE_BITS  = 40;
    localparam int SAT_BITS   = 32;

    // Configuration port geometry.
    localparam int ADDR_BITS = 6;
    localparam int DATA_BITS = 64;
    localparam int SEL_LSB   = 3;
    localparam int SEL_BITS  = 3;

    localparam logic signed [PX_BITS-1:0] PX_HALF = PX_BITS'(2 ** (FRACT_BITS - 1));

    // Register map.
    typedef enum logic [SEL_BITS-1:0] {
        REG_FORWARD,
        REG_LEFT,
        REG_UP,
        REG_FOV,
        REG_FRAME,
        REG_OSIZE,
        REG_OORIGIN,
        REG_CAMPOS
    } reg_sel_t;

    // Per-request sideband that travels with the direction math.
    typedef struct packed {
        logic [2:0]          neg;
        logic                zero;
        logic [POS_BITS-1:0] org_x;
        logic [POS_BITS-1:0] org_y;
    } side_t;

    localparam logic signed [WIDE_BITS-1:0] POS_MAX_W = WIDE_BITS'(2 ** (POS_BITS - 1) - 1);
    localparam logic signed [WIDE_BITS-1:0] POS_MIN_W = WIDE_BITS'(-(2 ** (POS_BITS - 1)));
    localparam logic signed [SAT_BITS-1:0]  DIR_MAX_W = SAT_BITS'(2 ** (DIR_BITS - 1) - 1);
    localparam logic signed [SAT_BITS-1:0]  DIR_MIN_W = SAT_BITS'(-(2 ** (DIR_BITS - 1)));

    // Clamp a wide signed value to the position range.
    function automatic logic [POS_BITS-1:0] sat_pos(input logic signed [WIDE_BITS-1:0] v);
        logic [POS_BITS-1:0] r;
        if (v > POS_MAX_W)
        begin
            r = POS_MAX_W[POS_BITS-1:0];
        end
        else if (v < POS_MIN_W)
        begin
            r = POS_MIN_W[POS_BITS-1:0];
        end
        else
        begin
            r = v[POS_BITS-1:0];
        end
        return r;
    endfunction

    // Clamp a signed value to the direction component range.
    function automatic logic [DIR_BITS-1:0] sat_dir(input logic signed [SAT_BITS-1:0] v);
        logic [DIR_BITS-1:0] r;
        if (v > DIR_MAX_W)
        begin
            r = DIR_MAX_W[DIR_BITS-1:0];
        end
        else if (v < DIR_MIN_W)
        begin
            r = DIR_MIN_W[DIR_BITS-1:0];
        end
        else
        begin
            r = v[DIR_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/camera_primary_ray_generator.sv @@
// Top level of the pinhole camera primary ray generator pipeline.
`default_nettype none

// Usage:
// A request is one pixel coordinate (pixel_x, pixel_y), taken at a rising edge where start
// is high and busy is low. busy is always low: the pipeline takes one request every cycle.
// Each request yields exactly one ray (origin and unit direction) on the result ports,
// marked by ray_valid for a single cycle, in request order.
// The pipeline holds the 16-step pixel-fraction divider, the 31-step square root and the
// DIR_FRAC_BITS + 1 step normalizing divider, each one bit per stage.
// Throughput is one ray per cycle.
// The registers are written through the APB-style port at byte address 8*i and must only
// be changed while no request is in flight. Reset clears the pipeline valid bits and sets
// the registers to their defaults (640 x 480 perspective, everything else zero).
// The receiver cannot stall; a ray is shown for one cycle and must be taken then.
module camera_primary_ray_generator #(
    parameter int PIXEL_BITS    = crg_pkg::PIXEL_BITS_DEF,
    parameter int DIR_FRAC_BITS = crg_pkg::DIR_FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [PIXEL_BITS-1:0]               pixel_x,
    input  wire logic [PIXEL_BITS-1:0]               pixel_y,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [crg_pkg::ADDR_BITS-1:0]       paddr,
    input  wire logic [crg_pkg::DATA_BITS-1:0]       pwdata,
    output logic [crg_pkg::DATA_BITS-1:0]            prdata,
    output logic                                     pready,
    output logic                                     ray_valid,
    output logic signed [crg_pkg::POS_BITS-1:0]      origin_x,
    output logic signed [crg_pkg::POS_BITS-1:0]      origin_y,
    output logic signed [crg_pkg::POS_BITS-1:0]      origin_z,
    output logic signed [crg_pkg::DIR_BITS-1:0]      dir_x,
    output logic signed [crg_pkg::DIR_BITS-1:0]      dir_y,
    output logic signed [crg_pkg::DIR_BITS-1:0]      dir_z
);
    import crg_pkg::*;

    localparam int FW      = 2 * PIXEL_BITS + 1;
    localparam int QB      = DIR_FRAC_BITS + 1;
    localparam int LATENCY = FRACT_BITS + ROOT_BITS + DIR_FRAC_BITS + 15;
    localparam logic [FW-1:0] FRAME_RESET = FW'(64'd640 | (64'd480 << PIXEL_BITS));
    localparam logic [DIR_BITS-1:0] DIR_ONE =
        (DIR_FRAC_BITS >= DIR_BITS - 1) ? DIR_MAX_W[DIR_BITS-1:0] : DIR_BITS'(2 ** DIR_FRAC_BITS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [3*VEC_BITS-1:0]   forward_reg;
    logic [3*VEC_BITS-1:0]   left_reg;
    logic [3*VEC_BITS-1:0]   up_reg;
    logic [2*SCALE_BITS-1:0] fov_reg;
    logic [FW-1:0]           frame_reg;
    logic [2*POS_BITS-1:0]   osize_reg;
    logic [3*POS_BITS-1:0]   oorigin_reg;
    logic [3*POS_BITS-1:0]   campos_reg;

    reg_sel_t cfg_sel;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_sel = reg_sel_t'(paddr[ADDR_BITS-1:SEL_LSB]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes complete in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forward_reg <= '0;
            left_reg    <= '0;
            up_reg      <= '0;
            fov_reg     <= '0;
            frame_reg   <= FRAME_RESET;
            osize_reg   <= '0;
            oorigin_reg <= '0;
            campos_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_FORWARD: forward_reg <= pwdata[3*VEC_BITS-1:0];
                REG_LEFT:    left_reg    <= pwdata[3*VEC_BITS-1:0];
                REG_UP:      up_reg      <= pwdata[3*VEC_BITS-1:0];
                REG_FOV:     fov_reg     <= pwdata[2*SCALE_BITS-1:0];
                REG_FRAME:   frame_reg   <= pwdata[FW-1:0];
                REG_OSIZE:   osize_reg   <= pwdata[2*POS_BITS-1:0];
                REG_OORIGIN: oorigin_reg <= pwdata[3*POS_BITS-1:0];
                REG_CAMPOS:  campos_reg  <= pwdata[3*POS_BITS-1:0];
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        unique case (cfg_sel)
            REG_FORWARD: prdata = DATA_BITS'(forward_reg);
            REG_LEFT:    prdata = DATA_BITS'(left_reg);
            REG_UP:      prdata = DATA_BITS'(up_reg);
            REG_FOV:     prdata = DATA_BITS'(fov_reg);
            REG_FRAME:   prdata = DATA_BITS'(frame_reg);
            REG_OSIZE:   prdata = DATA_BITS'(osize_reg);
            REG_OORIGIN: prdata = DATA_BITS'(oorigin_reg);
            REG_CAMPOS:  prdata = DATA_BITS'(campos_reg);
        endcase
    end

    // Frame fields; a zero size counts as one pixel.
    logic [PIXEL_BITS-1:0] size_w;
    logic [PIXEL_BITS-1:0] size_h;
    logic                  ortho_mode;

    always_comb
    begin
        size_w     = frame_reg[PIXEL_BITS-1:0];
        size_h     = frame_reg[2*PIXEL_BITS-1:PIXEL_BITS];
        ortho_mode = frame_reg[2*PIXEL_BITS];
        if (size_w == '0)
        begin
            size_w = PIXEL_BITS'(1);
        end
        if (size_h == '0)
        begin
            size_h = PIXEL_BITS'(1);
        end
    end

    // ------------------------------------------------------------------
    // Screen fraction divider: one quotient bit per stage
    // ------------------------------------------------------------------
    logic                  dv_valid_reg [0:FRACT_BITS];
    logic [PIXEL_BITS-1:0] dx_rem_reg   [0:FRACT_BITS];
    logic [PIXEL_BITS-1:0] dy_rem_reg   [0:FRACT_BITS];
    logic [FRACT_BITS-1:0] dx_quo_reg   [0:FRACT_BITS];
    logic [FRACT_BITS-1:0] dy_quo_reg   [0:FRACT_BITS];
    logic                  in_accept;

    assign in_accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            dv_valid_reg[0] <= in_accept;
        end
    end

    // Coordinates past the frame edge are clamped to the last pixel.
    always_ff @(posedge clk)
    begin
        dx_rem_reg[0] <= (pixel_x >= size_w) ? size_w - PIXEL_BITS'(1) : pixel_x;
        dy_rem_reg[0] <= (pixel_y >= size_h) ? size_h - PIXEL_BITS'(1) : pixel_y;
        dx_quo_reg[0] <= '0;
        dy_quo_reg[0] <= '0;
    end

    for (genvar k = 0; k < FRACT_BITS; k++)
    begin : g_pdiv
        logic [PIXEL_BITS:0] x_sh;
        logic [PIXEL_BITS:0] y_sh;
        logic                x_ge;
        logic                y_ge;

        always_comb
        begin
            x_sh = {dx_rem_reg[k], 1'b0};
            y_sh = {dy_rem_reg[k], 1'b0};
            x_ge = x_sh >= {1'b0, size_w};
            y_ge = y_sh >= {1'b0, size_h};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dx_rem_reg[k+1] <= x_ge ? PIXEL_BITS'(x_sh - {1'b0, size_w}) : PIXEL_BITS'(x_sh);
            dy_rem_reg[k+1] <= y_ge ? PIXEL_BITS'(y_sh - {1'b0, size_h}) : PIXEL_BITS'(y_sh);
            dx_quo_reg[k+1] <= {dx_quo_reg[k][FRACT_BITS-2:0], x_ge};
            dy_quo_reg[k+1] <= {dy_quo_reg[k][FRACT_BITS-2:0], y_ge};
        end
    end

    // ------------------------------------------------------------------
    // Stage A: fraction times FOV scale and orthographic size
    // ------------------------------------------------------------------
    logic signed [PX_BITS-1:0] px;
    logic signed [PX_BITS-1:0] py;
    logic                      a_valid_reg;
    logic signed [PS_BITS-1:0] a_psx_reg;
    logic signed [PS_BITS-1:0] a_psy_reg;
    logic signed [OP_BITS-1:0] a_oxp_reg;
    logic signed [OP_BITS-1:0] a_oyp_reg;

    assign px = signed'({1'b0, dx_quo_reg[FRACT_BITS]}) - PX_HALF;
    assign py = signed'({1'b0, dy_quo_reg[FRACT_BITS]}) - PX_HALF;

    always_ff @(posedge clk)
    begin
        a_psx_reg <= PS_BITS'(px) * PS_BITS'(signed'({1'b0, fov_reg[SCALE_BITS-1:0]}));
        a_psy_reg <= PS_BITS'(py) * PS_BITS'(signed'({1'b0, fov_reg[2*SCALE_BITS-1:SCALE_BITS]}));
        a_oxp_reg <= OP_BITS'(px) * OP_BITS'(signed'({1'b0, osize_reg[POS_BITS-1:0]}));
        a_oyp_reg <= OP_BITS'(py) * OP_BITS'(signed'({1'b0, osize_reg[2*POS_BITS-1:POS_BITS]}));
    end

    // ------------------------------------------------------------------
    // Stage B: basis products and orthographic origin
    // ------------------------------------------------------------------
    logic                        b_valid_reg;
    logic signed [LP_BITS-1:0]   b_lp_reg [0:2];
    logic signed [LP_BITS-1:0]   b_up_reg [0:2];
    side_t                       b_side_reg;
    logic signed [WIDE_BITS-1:0] ortho_x_sum;
    logic signed [WIDE_BITS-1:0] ortho_y_sum;

    always_comb
    begin
        ortho_x_sum = WIDE_BITS'(signed'(oorigin_reg[POS_BITS-1:0]))
                    + (WIDE_BITS'(a_oxp_reg) >>> FRACT_BITS);
        ortho_y_sum = WIDE_BITS'(signed'(oorigin_reg[2*POS_BITS-1:POS_BITS]))
                    + ((-WIDE_BITS'(a_oyp_reg)) >>> FRACT_BITS);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_lp_reg[i] <= LP_BITS'(signed'(left_reg[VEC_BITS*i +: VEC_BITS]))
                         * LP_BITS'(a_psx_reg);
            b_up_reg[i] <= LP_BITS'(signed'(up_reg[VEC_BITS*i +: VEC_BITS]))
                         * LP_BITS'(a_psy_reg);
        end
        b_side_reg.neg   <= '0;
        b_side_reg.zero  <= 1'b0;
        b_side_reg.org_x <= sat_pos(ortho_x_sum);
        b_side_reg.org_y <= sat_pos(ortho_y_sum);
    end

    // ------------------------------------------------------------------
    // Stage C: perspective direction sum
    // ------------------------------------------------------------------
    logic                     c_valid_reg;
    logic signed [V_BITS-1:0] c_v_reg [0:2];
    side_t                    c_side_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_v_reg[i] <= (V_BITS'(signed'(forward_reg[VEC_BITS*i +: VEC_BITS])) <<< FWD_SHIFT)
                        - V_BITS'(b_lp_reg[i]) - V_BITS'(b_up_reg[i]);
        end
        c_side_reg <= b_side_reg;
    end

    // ------------------------------------------------------------------
    // Normalizer: magnitudes, then a left shift of 32, 16, ... 1 per stage
    // ------------------------------------------------------------------
    logic                nm_valid_reg [0:NORM_STEPS];
    logic [MAG_BITS-1:0] nm_mag_reg   [0:NORM_STEPS][0:2];
    side_t               nm_side_reg  [0:NORM_STEPS];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            nm_mag_reg[0][i] <= c_v_reg[i][V_BITS-1] ? MAG_BITS'(-c_v_reg[i])
                                                     : MAG_BITS'(c_v_reg[i]);
            nm_side_reg[0].neg[i] <= c_v_reg[i][V_BITS-1];
        end
        nm_side_reg[0].zero  <= (c_v_reg[0] == '0) && (c_v_reg[1] == '0) && (c_v_reg[2] == '0);
        nm_side_reg[0].org_x <= c_side_reg.org_x;
        nm_side_reg[0].org_y <= c_side_reg.org_y;
    end

    for (genvar k = 0; k < NORM_STEPS; k++)
    begin : g_norm
        localparam int SH = (2 ** (NORM_STEPS - 1)) >> k;
        logic [MAG_BITS-1:0] mag_or;
        logic                do_shift;

        always_comb
        begin
            mag_or   = nm_mag_reg[k][0] | nm_mag_reg[k][1] | nm_mag_reg[k][2];
            do_shift = (mag_or[MAG_BITS-1 -: SH] == '0);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nm_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                nm_valid_reg[k+1] <= nm_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nm_mag_reg[k+1][i] <= do_shift ? (nm_mag_reg[k][i] << SH) : nm_mag_reg[k][i];
            end
            nm_side_reg[k+1] <= nm_side_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage E: squares of the normalized magnitudes
    // ------------------------------------------------------------------
    logic                 e_valid_reg;
    logic [NORM_BITS-1:0] e_mag_reg [0:2];
    logic [SQR_BITS-1:0]  e_sq_reg  [0:2];
    side_t                e_side_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_mag_reg[i] <= nm_mag_reg[NORM_STEPS][i][MAG_BITS-1 -: NORM_BITS];
            e_sq_reg[i]  <= SQR_BITS'(nm_mag_reg[NORM_STEPS][i][MAG_BITS-1 -: NORM_BITS])
                          * SQR_BITS'(nm_mag_reg[NORM_STEPS][i][MAG_BITS-1 -: NORM_BITS]);
        end
        e_side_reg <= nm_side_reg[NORM_STEPS];
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage
    // ------------------------------------------------------------------
    logic                 sq_valid_reg [0:ROOT_BITS];
    logic [SQ_BITS-1:0]   sq_rad_reg   [0:ROOT_BITS];
    logic [REM_BITS-1:0]  sq_rem_reg   [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] sq_root_reg  [0:ROOT_BITS];
    logic [NORM_BITS-1:0] sq_mag_reg   [0:ROOT_BITS][0:2];
    side_t                sq_side_reg  [0:ROOT_BITS];

    always_ff @(posedge clk)
    begin
        sq_rad_reg[0]  <= SQ_BITS'(e_sq_reg[0]) + SQ_BITS'(e_sq_reg[1]) + SQ_BITS'(e_sq_reg[2]);
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        for (int i = 0; i < 3; i++)
        begin
            sq_mag_reg[0][i] <= e_mag_reg[i];
        end
        sq_side_reg[0] <= e_side_reg;
    end

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_sqrt
        logic [REM_BITS-1:0] rem_sh;
        logic [REM_BITS-1:0] trial;
        logic                ge;

        always_comb
        begin
            rem_sh = {sq_rem_reg[k][REM_BITS-3:0], sq_rad_reg[k][SQ_BITS-1 -: 2]};
            trial  = REM_BITS'({sq_root_reg[k], 2'b01});
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_rad_reg[k+1]  <= {sq_rad_reg[k][SQ_BITS-3:0], 2'b00};
            sq_rem_reg[k+1]  <= ge ? rem_sh - trial : rem_sh;
            sq_root_reg[k+1] <= {sq_root_reg[k][ROOT_BITS-2:0], ge};
            for (int i = 0; i < 3; i++)
            begin
                sq_mag_reg[k+1][i] <= sq_mag_reg[k][i];
            end
            sq_side_reg[k+1] <= sq_side_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Normalizing divider: magnitude / length, one quotient bit per stage
    // ------------------------------------------------------------------
    logic                 qd_valid_reg [0:DIR_FRAC_BITS];
    logic [ROOT_BITS-1:0] qd_root_reg  [0:DIR_FRAC_BITS];
    logic [ROOT_BITS-1:0] qd_rem_reg   [0:DIR_FRAC_BITS][0:2];
    logic [QB-1:0]        qd_quo_reg   [0:DIR_FRAC_BITS][0:2];
    side_t                qd_side_reg  [0:DIR_FRAC_BITS];
    logic [2:0]           int_ge;

    // Integer quotient bit: the magnitude never exceeds the length.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            int_ge[i] = ROOT_BITS'(sq_mag_reg[ROOT_BITS][i]) >= sq_root_reg[ROOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        qd_root_reg[0] <= sq_root_reg[ROOT_BITS];
        for (int i = 0; i < 3; i++)
        begin
            qd_rem_reg[0][i] <= int_ge[i]
                ? ROOT_BITS'(sq_mag_reg[ROOT_BITS][i]) - sq_root_reg[ROOT_BITS]
                : ROOT_BITS'(sq_mag_reg[ROOT_BITS][i]);
            qd_quo_reg[0][i] <= QB'(int_ge[i]);
        end
        qd_side_reg[0] <= sq_side_reg[ROOT_BITS];
    end

    for (genvar k = 0; k < DIR_FRAC_BITS; k++)
    begin : g_qdiv
        logic [ROOT_BITS:0] r_sh [0:2];
        logic [2:0]         ge;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                r_sh[i] = {qd_rem_reg[k][i], 1'b0};
                ge[i]   = r_sh[i] >= {1'b0, qd_root_reg[k]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                qd_valid_reg[k+1] <= 1'b0;
            end
            else
            begin
                qd_valid_reg[k+1] <= qd_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            qd_root_reg[k+1] <= qd_root_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                qd_rem_reg[k+1][i] <= ge[i] ? ROOT_BITS'(r_sh[i] - {1'b0, qd_root_reg[k]})
                                            : ROOT_BITS'(r_sh[i]);
                qd_quo_reg[k+1][i] <= {qd_quo_reg[k][i][QB-2:0], ge[i]};
            end
            qd_side_reg[k+1] <= qd_side_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Valid bits of the single stages
    // ------------------------------------------------------------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            nm_valid_reg[0] <= 1'b0;
            e_valid_reg     <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
            qd_valid_reg[0] <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            a_valid_reg     <= dv_valid_reg[FRACT_BITS];
            b_valid_reg     <= a_valid_reg;
            c_valid_reg     <= b_valid_reg;
            nm_valid_reg[0] <= c_valid_reg;
            e_valid_reg     <= nm_valid_reg[NORM_STEPS];
            sq_valid_reg[0] <= e_valid_reg;
            qd_valid_reg[0] <= sq_valid_reg[ROOT_BITS];
            out_valid_reg   <= qd_valid_reg[DIR_FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sign, saturation and mode select
    // ------------------------------------------------------------------
    logic signed [QB:0]         dir_signed [0:2];
    logic        [DIR_BITS-1:0] dir_sat    [0:2];
    side_t                      last_side;
    logic        [POS_BITS-1:0] org_x_next;
    logic        [POS_BITS-1:0] org_y_next;
    logic        [POS_BITS-1:0] org_z_next;
    logic        [DIR_BITS-1:0] dir_x_next;
    logic        [DIR_BITS-1:0] dir_y_next;
    logic        [DIR_BITS-1:0] dir_z_next;
    logic        [POS_BITS-1:0] org_x_reg;
    logic        [POS_BITS-1:0] org_y_reg;
    logic        [POS_BITS-1:0] org_z_reg;
    logic        [DIR_BITS-1:0] dir_x_reg;
    logic        [DIR_BITS-1:0] dir_y_reg;
    logic        [DIR_BITS-1:0] dir_z_reg;

    assign last_side = qd_side_reg[DIR_FRAC_BITS];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dir_signed[i] = last_side.neg[i] ? -signed'({1'b0, qd_quo_reg[DIR_FRAC_BITS][i]})
                                             : signed'({1'b0, qd_quo_reg[DIR_FRAC_BITS][i]});
            dir_sat[i]    = last_side.zero ? '0 : sat_dir(SAT_BITS'(dir_signed[i]));
        end
        if (ortho_mode)
        begin
            org_x_next = last_side.org_x;
            org_y_next = last_side.org_y;
            org_z_next = oorigin_reg[3*POS_BITS-1:2*POS_BITS];
            dir_x_next = '0;
            dir_y_next = '0;
            dir_z_next = DIR_ONE;
        end
        else
        begin
            org_x_next = campos_reg[POS_BITS-1:0];
            org_y_next = campos_reg[2*POS_BITS-1:POS_BITS];
            org_z_next = campos_reg[3*POS_BITS-1:2*POS_BITS];
            dir_x_next = dir_sat[0];
            dir_y_next = dir_sat[1];
            dir_z_next = dir_sat[2];
        end
    end

    always_ff @(posedge clk)
    begin
        org_x_reg <= org_x_next;
        org_y_reg <= org_y_next;
        org_z_reg <= org_z_next;
        dir_x_reg <= dir_x_next;
        dir_y_reg <= dir_y_next;
        dir_z_reg <= dir_z_next;
    end

    assign ray_valid = out_valid_reg;
    assign origin_x  = signed'(org_x_reg);
    assign origin_y  = signed'(org_y_reg);
    assign origin_z  = signed'(org_z_reg);
    assign dir_x     = signed'(dir_x_reg);
    assign dir_y     = signed'(dir_y_reg);
    assign dir_z     = signed'(dir_z_reg);

`ifndef SYNTHESIS
    // Every accepted request gives a ray after the fixed latency, and no ray appears otherwise.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY ray_valid)
        else $error("ray missing after accepted request");

    assert property (@(posedge clk) disable iff (!rst_n)
        ray_valid |-> $past(start && !busy, LATENCY))
        else $error("ray without a matching request");

    // A nonzero direction leaves the normalizer with its leading one at the top bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (nm_valid_reg[NORM_STEPS] && !nm_side_reg[NORM_STEPS].zero)
            |-> (nm_mag_reg[NORM_STEPS][0][MAG_BITS-1] || nm_mag_reg[NORM_STEPS][1][MAG_BITS-1] ||
                 nm_mag_reg[NORM_STEPS][2][MAG_BITS-1]))
        else $error("normalizer lost the leading one");

    // The vector length is at least the largest normalized magnitude.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sq_valid_reg[ROOT_BITS] && !sq_side_reg[ROOT_BITS].zero)
            |-> (sq_root_reg[ROOT_BITS][ROOT_BITS-1:ROOT_BITS-2] != 2'b00))
        else $error("square root below normalized range");

    // Orthographic rays point straight down the z axis.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ray_valid && ortho_mode) |-> (dir_x == '0 && dir_y == '0))
        else $error("orthographic ray with lateral direction");
`endif

endmodule

`default_nettype wire

@@ dv/tb_camera_primary_ray_generator.sv @@
// Self-checking testbench for the camera primary ray generator: directed table plus random pixels.
`timescale 1ns / 100ps

module tb_camera_primary_ray_generator;
    import crg_pkg::*;

    localparam int PXB       = 12;
    localparam int DFB       = 14;
    localparam int LATENCY   = DFB + 62;
    localparam int N_RANDOM  = 600;
    localparam longint CYCLE_LIMIT = 400000;

    // One ray as seen on the result ports.
    typedef struct {
        logic signed [19:0] ox;
        logic signed [19:0] oy;
        logic signed [19:0] oz;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
    } ray_t;

    // One row of the directed table.
    typedef struct {
        logic [PXB-1:0] x;
        logic [PXB-1:0] y;
        bit             known;
        ray_t           ray;
    } pixel_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [PXB-1:0]       pixel_x;
    logic [PXB-1:0]       pixel_y;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 ray_valid;
    logic signed [19:0]   origin_x;
    logic signed [19:0]   origin_y;
    logic signed [19:0]   origin_z;
    logic signed [15:0]   dir_x;
    logic signed [15:0]   dir_y;
    logic signed [15:0]   dir_z;

    // Shadow copy of the register file.
    logic [47:0] fwd_vec;
    logic [47:0] left_vec;
    logic [47:0] up_vec;
    logic [31:0] fov;
    logic [24:0] frame_fmt;
    logic [39:0] osize;
    logic [59:0] oorigin;
    logic [59:0] campos;

    ray_t   expected_rays[$];
    int     mismatch_count;
    longint cycle_count;
    int     send_idle_pct;

    camera_primary_ray_generator #(
        .PIXEL_BITS   (PXB),
        .DIR_FRAC_BITS(DFB)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .ray_valid(ray_valid),
        .origin_x (origin_x),
        .origin_y (origin_y),
        .origin_z (origin_z),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z)
    );

    // Clock with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Sign-extended field of a packed register.
    function automatic longint sfield(input logic [63:0] v, input int lo, input int bits);
        logic [63:0] f;
        f = (v >> lo) & ((64'd1 << bits) - 64'd1);
        if (f[bits-1])
        begin
            return longint'(f) - (longint'(1) << bits);
        end
        return longint'(f);
    endfunction

    function automatic longint floor_asr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Screen fraction with 16 fraction bits, centered on zero.
    function automatic longint screen_fraction(input longint c, input longint size);
        if (size == 0)
        begin
            size = 1;
        end
        if (c >= size)
        begin
            c = size - 1;
        end
        return ((c << 16) / size) - 32768;
    endfunction

    function automatic longint int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Computes the ray that the block should give for one pixel.
    function automatic ray_t trace_pixel(input logic [PXB-1:0] x, input logic [PXB-1:0] y);
        ray_t        r;
        longint      px;
        longint      py;
        longint      v[3];
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] sq;
        longint      n;
        longint      q;
        longint      ow;
        longint      oh;
        px = screen_fraction(x, frame_fmt[PXB-1:0]);
        py = screen_fraction(y, frame_fmt[2*PXB-1:PXB]);
        if (frame_fmt[2*PXB])
        begin
            ow = osize[19:0];
            oh = osize[39:20];
            r.ox = 20'(clamp(sfield(oorigin, 0, 20) + floor_asr(px * ow, 16), -524288, 524287));
            r.oy = 20'(clamp(sfield(oorigin, 20, 20) + floor_asr(-(py * oh), 16),
                             -524288, 524287));
            r.oz = 20'(sfield(oorigin, 40, 20));
            r.dx = '0;
            r.dy = '0;
            r.dz = 16'sd1 <<< DFB;
            return r;
        end
        r.ox = 20'(sfield(campos, 0, 20));
        r.oy = 20'(sfield(campos, 20, 20));
        r.oz = 20'(sfield(campos, 40, 20));
        mx = '0;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = sfield(fwd_vec, 16 * i, 16) * (longint'(1) << 28)
                 - sfield(left_vec, 16 * i, 16) * px * longint'(fov[15:0])
                 - sfield(up_vec, 16 * i, 16) * py * longint'(fov[31:16]);
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx)
            begin
                mx = m[i];
            end
        end
        if (mx == 0)
        begin
            r.dx = '0;
            r.dy = '0;
            r.dz = '0;
            return r;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = m[i] >> 1;
            end
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = m[i] << 1;
            end
        end
        sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        n = int_sqrt(sq);
        for (int i = 0; i < 3; i++)
        begin
            q = longint'(m[i] << DFB) / n;
            q = clamp((v[i] < 0) ? -q : q, -32768, 32767);
            case (i)
                0: r.dx = 16'(q);
                1: r.dy = 16'(q);
                default: r.dz = 16'(q);
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Register write: setup cycle then access cycle, shadow updated alongside.
    task automatic write_reg(input reg_sel_t sel, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(sel) << SEL_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_FORWARD: fwd_vec   = value[47:0];
            REG_LEFT:    left_vec  = value[47:0];
            REG_UP:      up_vec    = value[47:0];
            REG_FOV:     fov       = value[31:0];
            REG_FRAME:   frame_fmt = value[24:0];
            REG_OSIZE:   osize     = value[39:0];
            REG_OORIGIN: oorigin   = value[59:0];
            default:     campos    = value[59:0];
        endcase
    endtask

    // Issue one request; the expected ray is queued when it is accepted.
    // start stays high afterwards so that requests can follow back to back.
    task automatic send_pixel(input logic [PXB-1:0] x, input logic [PXB-1:0] y,
                              input bit known, input ray_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        expected_rays.push_back(known ? want : trace_pixel(x, y));
    endtask

    task automatic drain;
        start <= 1'b0;
        while (expected_rays.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8)
        begin
            @(posedge clk);
        end
    endtask

    // Fresh random camera setup; ortho selects the projection.
    task automatic random_setup(input bit ortho, input bit tiny);
        logic [11:0] w;
        logic [11:0] h;
        w = tiny ? 12'($urandom_range(4)) : 12'($urandom_range(4095));
        h = tiny ? 12'($urandom_range(4)) : 12'($urandom_range(4095));
        write_reg(REG_FORWARD, {$urandom, $urandom});
        write_reg(REG_LEFT, {$urandom, $urandom});
        write_reg(REG_UP, {$urandom, $urandom});
        write_reg(REG_FOV, $urandom);
        write_reg(REG_FRAME, {ortho, h, w});
        write_reg(REG_OSIZE, {$urandom, $urandom});
        write_reg(REG_OORIGIN, {$urandom, $urandom});
        write_reg(REG_CAMPOS, {$urandom, $urandom});
    endtask

    // Result checker: every strobe must match the oldest expectation.
    always @(posedge clk)
    begin
        ray_t want;
        if (rst_n && ray_valid)
        begin
            if (expected_rays.size() == 0)
            begin
                $display("unexpected ray at cycle %0d", cycle_count);
                mismatch_count++;
            end
            else
            begin
                want = expected_rays.pop_front();
                if (origin_x !== want.ox) report_mismatch("origin_x", origin_x, want.ox);
                if (origin_y !== want.oy) report_mismatch("origin_y", origin_y, want.oy);
                if (origin_z !== want.oz) report_mismatch("origin_z", origin_z, want.oz);
                if (dir_x !== want.dx) report_mismatch("dir_x", dir_x, want.dx);
                if (dir_y !== want.dy) report_mismatch("dir_y", dir_y, want.dy);
                if (dir_z !== want.dz) report_mismatch("dir_z", dir_z, want.dz);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        pixel_row_t rows[$];
        ray_t       zero_ray;
        ray_t       ortho_ray;
        int         sent;
        int         phase;
        cycle_count    = 0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        rst_n   = 1'b0;
        start   = 1'b0;
        pixel_x = '0;
        pixel_y = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        fwd_vec   = '0;
        left_vec  = '0;
        up_vec    = '0;
        fov       = '0;
        frame_fmt = 25'd640 | (25'd480 << PXB);
        osize     = '0;
        oorigin   = '0;
        campos    = '0;
        repeat (3)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        // After reset every vector is zero, so each ray is all zeros.
        zero_ray = '{0, 0, 0, 0, 0, 0};
        rows.push_back('{12'd0, 12'd0, 1'b1, zero_ray});
        rows.push_back('{12'd4095, 12'd4095, 1'b1, zero_ray});
        rows.push_back('{12'd639, 12'd479, 1'b1, zero_ray});
        foreach (rows[i])
        begin
            send_pixel(rows[i].x, rows[i].y, rows[i].known, rows[i].ray);
        end
        drain();

        // Perspective camera looking along +z with extreme pixels and clamping.
        write_reg(REG_FORWARD, 48'h4000_0000_0000);
        write_reg(REG_LEFT, 48'h0000_0000_4000);
        write_reg(REG_UP, 48'h0000_4000_0000);
        write_reg(REG_FOV, 32'h1000_1000);
        write_reg(REG_CAMPOS, 60'h80000_7FFFF_12345);
        rows.delete();
        rows.push_back('{12'd0, 12'd0, 1'b0, zero_ray});
        rows.push_back('{12'd320, 12'd240, 1'b0, zero_ray});
        rows.push_back('{12'd4095, 12'd0, 1'b0, zero_ray});
        rows.push_back('{12'd0, 12'd4095, 1'b0, zero_ray});
        rows.push_back('{12'd2730, 12'd1365, 1'b0, zero_ray});
        foreach (rows[i])
        begin
            send_pixel(rows[i].x, rows[i].y, rows[i].known, rows[i].ray);
        end
        drain();

        // Saturating extremes: most negative and most positive vector components and largest scales.
        write_reg(REG_FORWARD, 48'h8000_8000_8000);
        write_reg(REG_LEFT, 48'h7FFF_8000_7FFF);
        write_reg(REG_UP, 48'h8000_7FFF_8000);
        write_reg(REG_FOV, 32'hFFFF_FFFF);
        write_reg(REG_FRAME, 25'h0FFF_FFF);
        send_pixel(12'd0, 12'd0, 1'b0, zero_ray);
        send_pixel(12'd4095, 12'd4095, 1'b0, zero_ray);
        send_pixel(12'd2048, 12'd0, 1'b0, zero_ray);
        drain();

        // Zero frame size is treated as one pixel.
        write_reg(REG_FRAME, 25'd0);
        send_pixel(12'd0, 12'd0, 1'b0, zero_ray);
        send_pixel(12'd4095, 12'd17, 1'b0, zero_ray);
        drain();

        // Orthographic mode with saturating origins; the direction is fixed.
        write_reg(REG_FRAME, {1'b1, 12'd4, 12'd4});
        write_reg(REG_OSIZE, 40'hFFFFF_FFFFF);
        write_reg(REG_OORIGIN, 60'h00000_7FFFF_7FFFF);
        ortho_ray = '{0, 0, 0, 0, 0, 16'sd1 <<< DFB};
        rows.delete();
        rows.push_back('{12'd0, 12'd0, 1'b0, ortho_ray});
        rows.push_back('{12'd3, 12'd3, 1'b0, ortho_ray});
        rows.push_back('{12'd4095, 12'd4095, 1'b0, ortho_ray});
        foreach (rows[i])
        begin
            send_pixel(rows[i].x, rows[i].y, rows[i].known, rows[i].ray);
        end
        drain();
        write_reg(REG_OORIGIN, 60'h80000_80000_80000);
        send_pixel(12'd0, 12'd4095, 1'b0, zero_ray);
        send_pixel(12'd4095, 12'd0, 1'b0, zero_ray);
        drain();

        // Random part in phases: sender idle at 31 percent, then at 46 percent, then back to back.
        sent = 0;
        phase = 0;
        while (sent < N_RANDOM)
        begin
            if (sent % 50 == 0)
            begin
                drain();
                send_idle_pct = (sent < 200) ? 31 : ((sent < 400) ? 46 : 0);
                random_setup(phase % 3 == 2, phase % 4 == 3);
                phase++;
            end
            if ($urandom_range(9) == 0)
            begin
                send_pixel(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                           1'b0, zero_ray);
            end
            else
            begin
                send_pixel(12'($urandom_range(frame_fmt[PXB-1:0])),
                           12'($urandom_range(frame_fmt[2*PXB-1:PXB])), 1'b0, zero_ray);
            end
            sent++;
        end

        drain();
        repeat (LATENCY + 20)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0 && expected_rays.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/crg_pkg.sv
hdl/camera_primary_ray_generator.sv
dv/tb_camera_primary_ray_generator.sv
